@@ src/mdp_pkg.sv @@
// Shared types, character codes and constants for the method descriptor parser.
`timescale 1ns / 1ps

package mdp_pkg;

    localparam int OFFSET_BITS = 16;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 56;
    localparam int KIND_W     = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PARAM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETURN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD    = 2'd2;

    // Descriptor characters
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_CLASS  = 8'h4C;
    localparam logic [7:0] CH_VOID   = 8'h56;
    localparam logic [7:0] CH_LONG   = 8'h4A;
    localparam logic [7:0] CH_DOUBLE = 8'h44;
    localparam logic [7:0] CH_BYTE   = 8'h42;
    localparam logic [7:0] CH_CHAR   = 8'h43;
    localparam logic [7:0] CH_FLOAT  = 8'h46;
    localparam logic [7:0] CH_INT    = 8'h49;
    localparam logic [7:0] CH_SHORT  = 8'h53;
    localparam logic [7:0] CH_BOOL   = 8'h5A;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [3:0] {
        PH_WAIT_OPEN = 4'b0001,
        PH_PARAMS    = 4'b0010,
        PH_RETURN    = 4'b0100,
        PH_DONE      = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   in_class;
        logic                   in_array;
        logic [OFFSET_BITS-1:0] offset;
        logic [7:0]             param_cnt;
        logic [7:0]             slot_cnt;
        logic                   overflow;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_WAIT_OPEN,
        in_class:  1'b0,
        in_array:  1'b0,
        offset:    '0,
        param_cnt: 8'd0,
        slot_cnt:  8'd0,
        overflow:  1'b0
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        param_index;
        logic [15:0]       byte_offset;
        logic [7:0]        first_slot;
        logic [1:0]        slot_width;
        logic [7:0]        param_total;
        logic [7:0]        slot_total;
        logic              slots_overflow;
    } result_t;

    function automatic logic is_base_type(input logic [7:0] c);
        return (c == CH_BYTE) || (c == CH_CHAR) || (c == CH_DOUBLE) || (c == CH_FLOAT) ||
               (c == CH_INT) || (c == CH_LONG) || (c == CH_SHORT) || (c == CH_BOOL);
    endfunction

endpackage

@@ src/mdp_step.sv @@
// Per-byte parse step: next parser state and the result caused by one byte.
`timescale 1ns / 1ps

module mdp_step
    import mdp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   desc_byte,
    input  logic         last_byte,
    output parse_state_t nxt,
    output logic         res_valid,
    output result_t      res
);

    logic                   fin;
    logic                   bad;
    logic [1:0]             fin_width;
    logic [8:0]             slot_sum;
    logic [OFFSET_BITS-1:0] off_plus;
    parse_state_t           upd;

    assign off_plus = cur.offset + 1'b1;

    always_comb
    begin
        upd       = cur;
        upd.offset = off_plus;
        fin       = 1'b0;
        bad       = 1'b0;
        fin_width = 2'd1;
        slot_sum  = '0;
        res_valid = 1'b0;
        res       = '0;
        res.byte_offset = 16'(cur.offset);

        unique case (cur.phase)
            PH_WAIT_OPEN:
            begin
                if (desc_byte == CH_LPAREN)
                    upd.phase = PH_PARAMS;
                else
                    bad = 1'b1;
            end
            PH_PARAMS:
            begin
                if (cur.in_class) begin
                    if (desc_byte == CH_SEMI)
                        fin = 1'b1;
                end else if (desc_byte == CH_RPAREN && !cur.in_array) begin
                    upd.phase = PH_RETURN;
                end else if (desc_byte == CH_LBRACK) begin
                    upd.in_array = 1'b1;
                end else if (desc_byte == CH_CLASS) begin
                    upd.in_class = 1'b1;
                end else if (is_base_type(desc_byte)) begin
                    fin = 1'b1;
                    // Arrays of long or double are references and take one slot.
                    if (!cur.in_array && (desc_byte == CH_LONG || desc_byte == CH_DOUBLE))
                        fin_width = 2'd2;
                end else begin
                    bad = 1'b1;
                end
            end
            PH_RETURN:
            begin
                res_valid = 1'b1;
                upd.phase = PH_DONE;
                if (desc_byte == CH_VOID || desc_byte == CH_CLASS ||
                    desc_byte == CH_LBRACK || is_base_type(desc_byte))
                    res.kind = KIND_RETURN;
                else
                    res.kind = KIND_BAD;
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (bad) begin
            res_valid = 1'b1;
            res.kind  = KIND_BAD;
            upd.phase = PH_DONE;
        end

        if (fin) begin
            slot_sum        = {1'b0, cur.slot_cnt} + {7'd0, fin_width};
            res_valid       = 1'b1;
            res.kind        = KIND_PARAM;
            res.param_index = cur.param_cnt;
            res.first_slot  = cur.slot_cnt;
            res.slot_width  = fin_width;
            res.byte_offset = 16'(off_plus);
            if (cur.param_cnt != COUNT_MAX)
                upd.param_cnt = cur.param_cnt + 8'd1;
            if (slot_sum[8]) begin
                upd.slot_cnt = COUNT_MAX;
                upd.overflow = 1'b1;
            end else begin
                upd.slot_cnt = slot_sum[7:0];
            end
            upd.in_class = 1'b0;
            upd.in_array = 1'b0;
        end

        // Totals reflect the counters after this byte, before any end-of-descriptor reset.
        res.param_total    = upd.param_cnt;
        res.slot_total     = upd.slot_cnt;
        res.slots_overflow = upd.overflow;

        nxt = last_byte ? STATE_RESET : upd;
    end

endmodule

@@ src/mdp_out_reg.sv @@
// Result register driving the master stream side.
`timescale 1ns / 1ps

module mdp_out_reg
    import mdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  result_t               res,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]     m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {5'd0, res_reg.slots_overflow, res_reg.slot_total,
                       res_reg.param_total, res_reg.slot_width, res_reg.first_slot,
                       res_reg.byte_offset, res_reg.param_index};

endmodule

@@ src/method_descriptor_parser_unit.sv @@
// Top level of the method descriptor parser: input register, parser state and result path.
//
//  Channel   Dir  Data                              Sideband
//  s_axis    in   tdata[7:0] desc_byte              tlast last_byte
//  m_axis    out  tdata[55:0] parameter/totals      tuser[1:0] kind
//
// Each byte is held in the input register and parsed by the combinational step logic,
// which also forms the next parser state; any result is loaded into the result register.
// One byte is taken per cycle while the result register is free.
// Reset is asynchronous and active low; it returns the parser to waiting for '('.
// A stalled result register holds the input register, which then drops s_tready.
`timescale 1ns / 1ps

module method_descriptor_parser_unit
    import mdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] desc_byte
    input  logic                  s_tlast,   // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [7:0] param_index, [23:8] byte_offset,
                                             // [31:24] first_slot, [33:32] slot_width,
                                             // [41:34] param_total, [49:42] slot_total,
                                             // [50] slots_overflow, [55:51] zero
    output logic [KIND_W-1:0]     m_tuser    // [1:0] kind
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         res_valid;
    result_t      res;
    logic         out_free;
    logic         advance;

    // A byte leaves the input register once the result register can take its result.
    assign advance       = in_valid_reg && out_free;
    assign s_tready      = !in_valid_reg || advance;
    assign in_valid_next = (s_tvalid && s_tready) || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    mdp_step u_step (
        .cur       (state_reg),
        .desc_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    mdp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ src/mdp_checker.sv @@
// Port-level assertions for the method descriptor parser and their bind.
`timescale 1ns / 1ps

module mdp_checker
    import mdp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]     m_tuser
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == KIND_PARAM || m_tuser == KIND_RETURN || m_tuser == KIND_BAD))
        else $error("undefined result kind");

    a_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_PARAM |-> (m_tdata[33:32] == 2'd1 || m_tdata[33:32] == 2'd2))
        else $error("parameter result with bad slot width");

    a_nonparam: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_PARAM |->
            m_tdata[7:0] == 8'd0 && m_tdata[31:24] == 8'd0 && m_tdata[33:32] == 2'd0)
        else $error("non-parameter result carries parameter fields");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[50] |-> m_tdata[49:42] == COUNT_MAX)
        else $error("slot overflow without saturated total");

endmodule

bind method_descriptor_parser_unit mdp_checker u_mdp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/method_descriptor_parser_unit_tb.sv @@
// Self-checking testbench for the method descriptor parser unit.
`timescale 1ns / 1ps

module method_descriptor_parser_unit_tb;
    import mdp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 1250;

    localparam logic [7:0] TYPE_LETTERS [8] = '{CH_BYTE, CH_CHAR, CH_DOUBLE, CH_FLOAT,
                                                CH_INT, CH_LONG, CH_SHORT, CH_BOOL};

    typedef logic [7:0] byte_q_t[$];

    // Tracks the parser state and keeps the results each accepted byte should produce.
    class descriptor_tracker;
        phase_t      phase;
        logic        in_class;
        logic        in_array;
        logic [15:0] offset;
        logic [7:0]  params;
        logic [7:0]  slots;
        logic        ovf;
        result_t     pending[$];
        int          errors;
        int          parsed_bytes;
        int          seen_kind[3];
        int          overflow_hits;

        function new();
            restart();
        endfunction

        function void restart();
            phase    = PH_WAIT_OPEN;
            in_class = 1'b0;
            in_array = 1'b0;
            offset   = '0;
            params   = '0;
            slots    = '0;
            ovf      = 1'b0;
        endfunction

        function logic type_letter(logic [7:0] c);
            return c inside {CH_BYTE, CH_CHAR, CH_DOUBLE, CH_FLOAT,
                             CH_INT, CH_LONG, CH_SHORT, CH_BOOL};
        endfunction

        function void queue_result(logic [KIND_W-1:0] kind, logic [7:0] idx,
                                   logic [15:0] at, logic [7:0] first, logic [1:0] w);
            result_t r;
            r.kind           = kind;
            r.param_index    = idx;
            r.byte_offset    = at;
            r.first_slot     = first;
            r.slot_width     = w;
            r.param_total    = params;
            r.slot_total     = slots;
            r.slots_overflow = ovf;
            pending.push_back(r);
        endfunction

        // Return type or malformed byte: both end the parse until the last byte.
        function void end_parse(logic [KIND_W-1:0] kind, logic [15:0] at);
            queue_result(kind, 8'd0, at, 8'd0, 2'd0);
            phase = PH_DONE;
        endfunction

        function void close_param(logic [15:0] at, logic [1:0] w);
            logic [7:0] idx;
            logic [7:0] first;
            logic [8:0] sum;
            idx   = params;
            first = slots;
            sum   = {1'b0, slots} + {7'd0, w};
            if (params != COUNT_MAX)
                params = params + 8'd1;
            if (sum > {1'b0, COUNT_MAX})
            begin
                slots = COUNT_MAX;
                ovf   = 1'b1;
            end
            else
                slots = sum[7:0];
            in_class = 1'b0;
            in_array = 1'b0;
            queue_result(KIND_PARAM, idx, at + 16'd1, first, w);
        endfunction

        function void note_byte(logic [7:0] c, logic lst);
            logic [15:0] here;
            here   = offset;
            offset = offset + 16'd1;
            if (phase != PH_DONE)
                parsed_bytes++;
            case (phase)
                PH_WAIT_OPEN:
                    if (c == CH_LPAREN)
                        phase = PH_PARAMS;
                    else
                        end_parse(KIND_BAD, here);
                PH_PARAMS:
                    if (in_class)
                    begin
                        if (c == CH_SEMI)
                            close_param(here, 2'd1);
                    end
                    else if (c == CH_RPAREN && !in_array)
                        phase = PH_RETURN;
                    else if (c == CH_LBRACK)
                        in_array = 1'b1;
                    else if (c == CH_CLASS)
                        in_class = 1'b1;
                    else if (type_letter(c))
                        close_param(here, (!in_array && (c == CH_LONG || c == CH_DOUBLE))
                                          ? 2'd2 : 2'd1);
                    else
                        end_parse(KIND_BAD, here);
                PH_RETURN:
                    end_parse((c == CH_VOID || c == CH_CLASS || c == CH_LBRACK ||
                               type_letter(c)) ? KIND_RETURN : KIND_BAD, here);
                default:
                    ;
            endcase
            if (lst)
                restart();
        endfunction

        function void check_result(result_t got);
            result_t         want;
            string           names[8];
            longint unsigned want_v[8];
            longint unsigned got_v[8];
            if (pending.size() == 0)
            begin
                $error("result with no request waiting: kind %0d offset %0d",
                       got.kind, got.byte_offset);
                errors++;
                return;
            end
            want  = pending.pop_front();
            names = '{"kind", "param_index", "byte_offset", "first_slot", "slot_width",
                      "param_total", "slot_total", "slots_overflow"};
            want_v = '{want.kind, want.param_index, want.byte_offset, want.first_slot,
                       want.slot_width, want.param_total, want.slot_total,
                       want.slots_overflow};
            got_v  = '{got.kind, got.param_index, got.byte_offset, got.first_slot,
                       got.slot_width, got.param_total, got.slot_total,
                       got.slots_overflow};
            for (int i = 0; i < 8; i++)
            begin
                if (want_v[i] != got_v[i])
                begin
                    $error("%s: expected %0d, actual %0d", names[i], want_v[i], got_v[i]);
                    errors++;
                end
            end
            if (want.kind <= KIND_BAD)
                seen_kind[want.kind]++;
            if (want.slots_overflow)
                overflow_hits++;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;

    descriptor_tracker tracker = new();
    int                cycle_count = 0;
    int                input_stalls = 0;
    int                long_holds = 0;
    bit                quiet = 1'b0;
    bit                hold_ask = 1'b0;

    method_descriptor_parser_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (s_tvalid && !s_tready)
            input_stalls <= input_stalls + 1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("method_descriptor_parser_unit verification failed");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, plus one long hold when asked for.
    initial
    begin
        int      stall;
        result_t got;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_ask)
            begin
                hold_ask = 1'b0;
                stall    = 400;
                long_holds++;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.kind           = m_tuser;
                got.param_index    = m_tdata[7:0];
                got.byte_offset    = m_tdata[23:8];
                got.first_slot     = m_tdata[31:24];
                got.slot_width     = m_tdata[33:32];
                got.param_total    = m_tdata[41:34];
                got.slot_total     = m_tdata[49:42];
                got.slots_overflow = m_tdata[50];
                tracker.check_result(got);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_byte(b, lst);
    endtask

    task automatic send_desc(input byte_q_t q);
        foreach (q[i])
            push_byte(q[i], i == q.size() - 1);
    endtask

    // The sender stops and waits until every pending result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending.size() != 0);
    endtask

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SEMI);
        return b;
    endfunction

    function automatic void add_class(ref byte_q_t q);
        int len;
        len = $urandom_range(0, 6);
        q.push_back(CH_CLASS);
        repeat (len) q.push_back(name_byte());
        q.push_back(CH_SEMI);
    endfunction

    // One field type: optional array prefix, then a base letter or a class name.
    function automatic void add_type(ref byte_q_t q);
        int depth;
        depth = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
        repeat (depth) q.push_back(CH_LBRACK);
        if ($urandom_range(0, 9) < 8)
            q.push_back(TYPE_LETTERS[3'($urandom_range(0, 7))]);
        else
            add_class(q);
    endfunction

    function automatic void build_method(ref byte_q_t q, input int nparams);
        int r;
        q.push_back(CH_LPAREN);
        repeat (nparams) add_type(q);
        q.push_back(CH_RPAREN);
        r = $urandom_range(0, 9);
        if (r < 3)
            q.push_back(CH_VOID);
        else
            add_type(q);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial
    begin
        byte_q_t q;
        int      target;
        int      r;
        int      k;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: widths, arrays, empty class name, and each kind of bad byte.
        send_desc('{CH_LPAREN, CH_LONG, CH_DOUBLE, CH_LBRACK, CH_LONG, CH_CLASS, CH_SEMI,
                    CH_RPAREN, CH_VOID});
        send_desc('{8'h00});
        send_desc('{CH_LPAREN, CH_VOID});
        send_desc('{CH_LPAREN, CH_LBRACK, CH_RPAREN});
        send_desc('{CH_LPAREN, CH_RPAREN, 8'h51});
        send_desc('{CH_LPAREN});
        send_desc('{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_INT});
        send_desc('{CH_LPAREN, CH_LPAREN});
        drain();

        // Hold the result side for a long stretch while a long parameter list is offered.
        q = {};
        q.push_back(CH_LPAREN);
        repeat (60) q.push_back(CH_INT);
        q.push_back(CH_RPAREN);
        q.push_back(CH_VOID);
        hold_ask = 1'b1;
        quiet    = 1'b1;
        send_desc(q);
        quiet    = 1'b0;
        drain();

        // Enough parameters to saturate both the parameter and the slot counters.
        q = {};
        q.push_back(CH_LPAREN);
        repeat (300)
        begin
            r = $urandom_range(0, 3);
            q.push_back(r == 0 ? CH_INT : (r == 1 ? CH_DOUBLE : CH_LONG));
        end
        q.push_back(CH_RPAREN);
        q.push_back(CH_LONG);
        send_desc(q);
        drain();

        // Random: mostly well-formed descriptors, mixed with corrupted, cut short and noise.
        target = tracker.parsed_bytes + RANDOM_BYTES;
        while (tracker.parsed_bytes < target)
        begin
            q = {};
            quiet = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            if (r < 92)
                build_method(q, $urandom_range(0, 8));
            if (r >= 70 && r < 85)
            begin
                k = $urandom_range(0, q.size() - 1);
                q[k] = 8'($urandom_range(0, 255));
            end
            else if (r >= 85 && r < 92)
            begin
                k = $urandom_range(1, q.size() - 1);
                while (q.size() > k)
                    void'(q.pop_back());
            end
            else if (r >= 92)
            begin
                if ($urandom_range(0, 1) == 0)
                    q.push_back(CH_LPAREN);
                repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
            end
            send_desc(q);
        end
        quiet = 1'b0;

        drain();
        repeat (8) @(posedge clk);

        $display("Parsed %0d descriptor bytes: %0d parameter, %0d return, %0d malformed results.",
                 tracker.parsed_bytes, tracker.seen_kind[KIND_PARAM],
                 tracker.seen_kind[KIND_RETURN], tracker.seen_kind[KIND_BAD]);
        $display("Input held off %0d cycles, %0d long result holds, %0d saturated results.",
                 input_stalls, long_holds, tracker.overflow_hits);
        if (tracker.errors == 0)
            $display("method_descriptor_parser_unit verification clean");
        else
            $display("method_descriptor_parser_unit verification failed");
        $finish;
    end

endmodule
